// ===== hw/rtl/icr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package icr_pkg;

  // Number of interrupt sources held in status and enable
  localparam int unsigned NUM_SOURCES = 4;
  localparam int unsigned LINE_W      = 4;
  localparam int unsigned WORD_W      = 32;

  localparam logic [WORD_W-1:0] NO_VECTOR = '1;

  // Bus access codes
  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2,
    ACC_RSVD  = 2'd3
  } icr_acc_t;

  // Register window, word index
  typedef enum logic [2:0] {
    REG_STATUS  = 3'd0,
    REG_PENDING = 3'd1,
    REG_ENABLE  = 3'd2,
    REG_ACK     = 3'd3,
    REG_SETEN   = 3'd4,
    REG_CLREN   = 3'd5,
    REG_VECTOR  = 3'd6,
    REG_MASTER  = 3'd7
  } icr_reg_t;

  typedef logic [NUM_SOURCES-1:0] icr_src_t;

  // Architectural state of the controller
  typedef struct packed {
    icr_src_t status;
    icr_src_t enable;
    logic     master;
  } icr_state_t;

  // One registered request
  typedef struct packed {
    icr_acc_t          access;
    icr_reg_t          reg_index;
    logic [WORD_W-1:0] write_data;
    logic [LINE_W-1:0] irq_lines;
  } icr_req_t;

  // One result
  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq_out;
  } icr_rsp_t;

  // Lowest-numbered set bit, or all ones when none is set
  function automatic logic [WORD_W-1:0] lowest_pending(input icr_src_t pend);
    logic [WORD_W-1:0] vec;
    vec = NO_VECTOR;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (pend[i]) begin
        vec = WORD_W'(i);
      end
    end
    return vec;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/interrupt_controller_registers_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------
// input    | in_valid / in_stall   | access, reg_index, write_data, irq_lines
// output   | out_valid / out_stall | read_data, irq_out
//
// One item per cycle while the output does not stall; each item passes the input
// register, then the result register, with the update logic between.
// Controller state changes as an item moves into the result register.
// Reset clears status, enable, master enable and both valid flags.
// A stalled output freezes the pipeline; in_stall rises only while a result
// waits and the input register is full.
module interrupt_controller_registers_unit (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [1:0]  access,
  input  wire [2:0]  reg_index,
  input  wire [31:0] write_data,
  input  wire [3:0]  irq_lines,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [31:0] read_data,
  output logic       irq_out
);
  import icr_pkg::*;

  icr_state_t st;
  icr_state_t st_next;
  icr_req_t   req;
  icr_rsp_t   rsp_next;
  icr_rsp_t   rsp;
  logic       req_valid;
  logic       advance;
  logic       load_req;

  // Pipeline moves whenever the result register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign load_req = !req_valid || advance;
  assign in_stall = !load_req;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (load_req) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_req && in_valid) begin
      req.access     <= icr_acc_t'(access);
      req.reg_index  <= icr_reg_t'(reg_index);
      req.write_data <= write_data;
      req.irq_lines  <= irq_lines;
    end
  end

  icr_core u_core (
    .st      (st),
    .req     (req),
    .st_next (st_next),
    .rsp     (rsp_next)
  );

  // Controller state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance && req_valid) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      rsp <= rsp_next;
    end
  end

  assign read_data = rsp.read_data;
  assign irq_out   = rsp.irq_out;

endmodule

`default_nettype wire

// ===== hw/rtl/icr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-pass update: latch lines, service the access, work out irq_out
module icr_core (
  input  wire icr_pkg::icr_state_t st,
  input  wire icr_pkg::icr_req_t   req,
  output icr_pkg::icr_state_t      st_next,
  output icr_pkg::icr_rsp_t        rsp
);
  import icr_pkg::*;

  logic [WORD_W-1:0] lines_w;
  icr_src_t          latched;
  icr_src_t          pend;
  icr_src_t          data_m;
  icr_state_t        upd;

  // Sticky latch of the request lines, extra bits dropped
  assign lines_w = WORD_W'(req.irq_lines);
  assign latched = st.status | lines_w[NUM_SOURCES-1:0];
  assign pend    = latched & st.enable;
  assign data_m  = req.write_data[NUM_SOURCES-1:0];

  // Read mux sees the state after the latch; irq_out from the updated state
  always_comb begin
    rsp.read_data = '0;
    rsp.irq_out   = upd.master & (|(upd.status & upd.enable));
    if (req.access == ACC_READ) begin
      case (req.reg_index)
        REG_STATUS:  rsp.read_data = WORD_W'(latched);
        REG_PENDING: rsp.read_data = WORD_W'(pend);
        REG_ENABLE:  rsp.read_data = WORD_W'(st.enable);
        REG_VECTOR:  rsp.read_data = lowest_pending(pend);
        REG_MASTER:  rsp.read_data = WORD_W'(st.master);
        default:     rsp.read_data = '0;
      endcase
    end
  end

  // Register writes
  always_comb begin
    upd        = st;
    upd.status = latched;
    if (req.access == ACC_WRITE) begin
      case (req.reg_index)
        REG_STATUS: upd.status = latched | data_m;
        REG_ENABLE: upd.enable = data_m;
        REG_ACK:    upd.status = latched & ~data_m;
        REG_SETEN:  upd.enable = st.enable | data_m;
        REG_CLREN:  upd.enable = st.enable & ~data_m;
        REG_MASTER: upd.master = req.write_data[0];
        default:    upd = upd;
      endcase
    end
  end

  assign st_next = upd;

endmodule

`default_nettype wire

// ===== hw/rtl/icr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the controller's pipeline
module icr_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] read_data,
  input wire        irq_out
);

  // Reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Input only stalls while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  // Input register is empty straight after reset
  a_ready_after_reset: assert property (@(posedge clk) $past(rst) |-> !in_stall)
    else $error("input stalled after reset");

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(irq_out)))
    else $error("stalled result changed");

  // Accepted item reaches the output when the output is not stalled on the way
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_stall) ##1 !out_stall |=> out_valid)
    else $error("result missing after transfer");

endmodule

bind interrupt_controller_registers_unit icr_checker u_icr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .read_data (read_data),
  .irq_out   (irq_out)
);

`default_nettype wire

// ===== verif/interrupt_controller_registers_unit_test.sv =====
`timescale 1ns / 1ps

module interrupt_controller_registers_unit_test;
  import icr_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // Tracks controller state and the queue of results still owed by the block
  class icr_result_tracker;
    icr_src_t  status_q;
    icr_src_t  enable_q;
    logic      master_q;
    icr_rsp_t  owed_rsp[$];
    int        errors;

    function new();
      status_q = '0;
      enable_q = '0;
      master_q = 1'b0;
      errors   = 0;
    endfunction

    function int outstanding();
      return owed_rsp.size();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endfunction

    // Work out the result of one accepted transfer and update the state
    function void note_transfer(icr_acc_t acc, icr_reg_t idx, logic [31:0] data,
                                logic [3:0] lines);
      icr_src_t  pend;
      icr_src_t  bits;
      icr_rsp_t  rsp;
      logic [WORD_W-1:0] vec;
      rsp.read_data = '0;
      // line sampling happens ahead of the bus access
      status_q = status_q | lines[NUM_SOURCES-1:0];
      pend = status_q & enable_q;
      bits = data[NUM_SOURCES-1:0];
      if (acc == ACC_READ) begin
        case (idx)
          REG_STATUS:  rsp.read_data = WORD_W'(status_q);
          REG_PENDING: rsp.read_data = WORD_W'(pend);
          REG_ENABLE:  rsp.read_data = WORD_W'(enable_q);
          REG_VECTOR: begin
            vec = NO_VECTOR;
            for (int i = 0; i < NUM_SOURCES; i++) begin
              if (pend[i] && vec == NO_VECTOR) begin
                vec = WORD_W'(i);
              end
            end
            rsp.read_data = vec;
          end
          REG_MASTER:  rsp.read_data = WORD_W'(master_q);
          default:     rsp.read_data = '0;
        endcase
      end else if (acc == ACC_WRITE) begin
        case (idx)
          REG_STATUS: status_q = status_q | bits;
          REG_ENABLE: enable_q = bits;
          REG_ACK:    status_q = status_q & ~bits;
          REG_SETEN:  enable_q = enable_q | bits;
          REG_CLREN:  enable_q = enable_q & ~bits;
          REG_MASTER: master_q = data[0];
          default:    ;
        endcase
      end
      rsp.irq_out = master_q & (|(status_q & enable_q));
      owed_rsp.push_back(rsp);
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check_result(logic [31:0] rd, logic irq);
      icr_rsp_t want;
      if (owed_rsp.size() == 0) begin
        note_error($sformatf("unexpected result read_data=%h irq_out=%b", rd, irq));
        return;
      end
      want = owed_rsp.pop_front();
      if (rd !== want.read_data) begin
        note_error($sformatf("read_data exp %h got %h", want.read_data, rd));
      end
      if (irq !== want.irq_out) begin
        note_error($sformatf("irq_out exp %b got %b", want.irq_out, irq));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  access;
  logic [2:0]  reg_index;
  logic [31:0] write_data;
  logic [3:0]  irq_lines;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic        irq_out;

  icr_result_tracker irq_tracker;
  int cycle_count;
  int items_sent;
  bit hold_req;

  interrupt_controller_registers_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .access     (access),
    .reg_index  (reg_index),
    .write_data (write_data),
    .irq_lines  (irq_lines),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .irq_out    (irq_out)
  );

  always #4 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offer one transfer, hold it until taken, then sometimes idle for a while
  task automatic send_item(input icr_acc_t acc, input icr_reg_t idx,
                           input logic [31:0] data, input logic [3:0] lines);
    int gap;
    in_valid   <= 1'b1;
    access     <= acc;
    reg_index  <= idx;
    write_data <= data;
    irq_lines  <= lines;
    do @(posedge clk); while (in_stall);
    irq_tracker.note_transfer(acc, idx, data, lines);
    items_sent++;
    gap = pick_gap(((items_sent / 200) % 3) == 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (irq_tracker.outstanding() > 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    icr_acc_t    acc;
    icr_reg_t    idx;
    logic [31:0] data;
    logic [3:0]  lines;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      acc = ACC_NONE;
    end else if (r < 55) begin
      acc = ACC_READ;
    end else if (r < 95) begin
      acc = ACC_WRITE;
    end else begin
      acc = ACC_RSVD;
    end
    idx = icr_reg_t'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 1) begin
      data = $urandom;
    end else begin
      data = $urandom_range(0, 15);
    end
    // keep lines quiet most of the time so acks can empty status
    if ($urandom_range(0, 3) == 0) begin
      lines = 4'($urandom_range(0, 15));
    end else begin
      lines = '0;
    end
    send_item(acc, idx, data, lines);
  endtask

  // Result side: take every transfer the block presents
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      irq_tracker.check_result(read_data, irq_out);
    end
  end

  // Result side back-pressure, with one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap(((cycle_count / 2000) % 3) == 0);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("interrupt_controller_registers_unit_test: done, errors");
    $finish;
  end

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    access     = ACC_NONE;
    reg_index  = REG_STATUS;
    write_data = '0;
    irq_lines  = '0;
    hold_req   = 1'b0;
    items_sent = 0;
    irq_tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset values, vector with nothing pending
    send_item(ACC_READ, REG_STATUS, 32'hffff_ffff, 4'h0);
    send_item(ACC_READ, REG_PENDING, 32'h0, 4'h0);
    send_item(ACC_READ, REG_ENABLE, 32'h0, 4'h0);
    send_item(ACC_READ, REG_VECTOR, 32'h0, 4'h0);
    send_item(ACC_READ, REG_MASTER, 32'h0, 4'h0);
    // master keeps bit 0 only
    send_item(ACC_WRITE, REG_MASTER, 32'hffff_fffe, 4'h0);
    send_item(ACC_WRITE, REG_MASTER, 32'hffff_ffff, 4'h0);
    send_item(ACC_READ, REG_MASTER, 32'h0, 4'h0);
    // enable replaced, upper data bits dropped
    send_item(ACC_WRITE, REG_ENABLE, 32'hffff_ffff, 4'h0);
    send_item(ACC_NONE, REG_STATUS, 32'h0, 4'hf);
    send_item(ACC_READ, REG_VECTOR, 32'h0, 4'h0);
    // ack against a line still high, then the line latches again
    send_item(ACC_WRITE, REG_ACK, 32'h0000_0001, 4'h1);
    send_item(ACC_READ, REG_STATUS, 32'h0, 4'h0);
    send_item(ACC_READ, REG_STATUS, 32'h0, 4'h1);
    send_item(ACC_WRITE, REG_ACK, 32'hffff_ffff, 4'h0);
    // software interrupts via status write
    send_item(ACC_WRITE, REG_STATUS, 32'hffff_fff4, 4'h0);
    send_item(ACC_READ, REG_VECTOR, 32'h0, 4'h0);
    // write-only registers read as zero
    send_item(ACC_READ, REG_ACK, 32'hffff_ffff, 4'h0);
    send_item(ACC_READ, REG_SETEN, 32'h0, 4'h0);
    send_item(ACC_READ, REG_CLREN, 32'h0, 4'h0);
    // read-only registers ignore writes; then enable clear and set, and a reserved access
    send_item(ACC_WRITE, REG_PENDING, 32'h0000_000f, 4'h0);
    send_item(ACC_WRITE, REG_VECTOR, 32'hffff_ffff, 4'h0);
    send_item(ACC_WRITE, REG_CLREN, 32'hffff_fffb, 4'h0);
    send_item(ACC_WRITE, REG_SETEN, 32'h0000_000a, 4'h0);
    send_item(ACC_RSVD, REG_ACK, 32'hffff_ffff, 4'h0);

    // Random transfers with one receiver hold-off and one full drain
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 300) begin
        hold_req = 1'b1;
      end
      if (k == 700) begin
        drain_results();
      end
      send_random_item();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (irq_tracker.errors == 0 && irq_tracker.outstanding() == 0) begin
      $display("interrupt_controller_registers_unit_test: done, clean");
    end else begin
      $display("interrupt_controller_registers_unit_test: done, errors");
    end
    $finish;
  end

endmodule
